FILE: rtl/core/plti_pkg.sv
// Shared types and constants for the piecewise-linear table interpolator.
// Used by plti_table, plti_mul, plti_div and piecewise_linear_table_interp_core.
package plti_pkg;

  localparam int DATA_W   = 32;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int CNT_W    = $clog2(DATA_W);
  localparam int IDX_W    = 4;
  localparam int CFG_W    = 5;
  localparam int STATUS_W = 2;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_SPAN = 2'd2;

  // Register index, taken from the word address bits of paddr.
  localparam logic [PADDR_W-3:0] REG_ENTRIES_IN_USE = '0;

  typedef struct packed {
    logic                     mode;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] x_value;
    logic signed [DATA_W-1:0] y_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [STATUS_W-1:0]      status;
  } out_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
  } entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ser_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK_FIRST,
    S_CHK_LAST,
    S_SCAN,
    S_SPAN,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

endpackage

FILE: rtl/core/plti_table.sv
// Breakpoint memory: one write port, one read port with registered read data.
// Depends on plti_pkg for the entry type.
module plti_table #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  plti_pkg::entry_t wdata,
  input  logic [AW-1:0]    raddr,
  output plti_pkg::entry_t rdata
);
  import plti_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/plti_mul.sv
// Bit-serial unsigned multiplier: one multiplier bit per cycle, LSB first.
// Depends on plti_pkg for widths and the status struct.
module plti_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [plti_pkg::DATA_W-1:0]   a,
  input  logic [plti_pkg::DATA_W-1:0]   b,
  output logic [plti_pkg::PROD_W-1:0]   product,
  output plti_pkg::ser_stat_t           stat
);
  import plti_pkg::*;

  logic [DATA_W-1:0] a_hold;
  logic [DATA_W-1:0] p_hi;
  logic [DATA_W-1:0] p_lo;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;
  logic [DATA_W:0]   sum;

  // The low half shifts right as multiplier bits are consumed and product bits come in.
  assign sum = {1'b0, p_hi} + (p_lo[0] ? {1'b0, a_hold} : '0);

  always_ff @(posedge clk) begin
    if (start) begin
      a_hold <= a;
      p_hi   <= '0;
      p_lo   <= b;
      cnt    <= '0;
    end else if (busy) begin
      p_hi <= sum[DATA_W:1];
      p_lo <= {sum[0], p_lo[DATA_W-1:1]};
      cnt  <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(DATA_W - 1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CNT_W'(DATA_W - 1))) begin
        busy <= 1'b0;
      end
    end
  end

  assign product   = {p_hi, p_lo};
  assign stat.busy = busy;
  assign stat.done = done;

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("multiplier started while busy");

endmodule

FILE: rtl/core/plti_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Depends on plti_pkg; the dividend's upper half must be below the divisor.
module plti_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [plti_pkg::PROD_W-1:0]   dividend,
  input  logic [plti_pkg::DATA_W-1:0]   divisor,
  output logic [plti_pkg::DATA_W-1:0]   quotient,
  output plti_pkg::ser_stat_t           stat
);
  import plti_pkg::*;

  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] qsh;
  logic [DATA_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;
  logic              ge;

  // The remainder stays below the divisor, so the shifted value fits one extra bit.
  assign shifted = {rem, qsh[DATA_W-1]};
  assign ge      = shifted >= {1'b0, dvs};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[PROD_W-1:DATA_W];
      qsh <= dividend[DATA_W-1:0];
      dvs <= divisor;
      cnt <= '0;
    end else if (busy) begin
      rem <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      qsh <= {qsh[DATA_W-2:0], ge};
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(DATA_W - 1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CNT_W'(DATA_W - 1))) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient  = qsh;
  assign stat.busy = busy;
  assign stat.done = done;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    start |-> (dividend[PROD_W-1:DATA_W] < divisor))
    else $error("divider started with a quotient that cannot fit");

endmodule

FILE: rtl/core/piecewise_linear_table_interp_core.sv
// Channel   Dir  Beat type          Handshake
// in        in   plti_pkg::in_item_t  in_valid / in_stall
// out       out  plti_pkg::out_item_t out_valid / out_stall
// cfg       in   APB register        psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// A write beat gives no result. An empty-table query goes straight to the result, and a
// clamped query checks the first breakpoint and, if needed, the last. An interpolated query
// also scans the table with one table read per scanned entry, then runs the bit-serial multiplier
// and the bit-serial divider. One query is in flight at a time; a finished result waits
// in the output register while the next beat is taken. Reset is synchronous and clears
// the entry count and all control state; table contents are undefined until written.
module piecewise_linear_table_interp_core #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  plti_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output plti_pkg::out_item_t               out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [plti_pkg::PADDR_W-1:0]      paddr,
  input  logic [plti_pkg::PDATA_W-1:0]      pwdata,
  output logic [plti_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);
  import plti_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int NW = AW + 1;

  state_t                   state;
  state_t                   state_next;
  logic [CFG_W-1:0]         cfg;
  logic [NW-1:0]            n_eff;
  logic [AW-1:0]            last_idx;
  logic                     in_acc;
  logic                     slot_ok;
  logic                     tbl_we;
  logic [AW-1:0]            raddr;
  entry_t                   rd;
  entry_t                   wr_entry;
  logic signed [DATA_W-1:0] qx;
  entry_t                   lo;
  entry_t                   hi;
  logic [AW-1:0]            idx;
  logic [DATA_W:0]          span33;
  logic [DATA_W:0]          dx33;
  logic [DATA_W:0]          dy33;
  logic [DATA_W:0]          dy_neg33;
  logic [DATA_W-1:0]        mag;
  logic                     span_pos;
  logic [DATA_W-1:0]        span_r;
  logic                     neg;
  logic                     mul_start;
  logic                     div_start;
  ser_stat_t                mul_stat;
  ser_stat_t                div_stat;
  logic [PROD_W-1:0]        product;
  logic [DATA_W-1:0]        quotient;
  logic signed [DATA_W+1:0] sum34;
  logic signed [DATA_W-1:0] sat;
  logic signed [DATA_W-1:0] res;
  logic [STATUS_W-1:0]      st;
  logic                     load_out;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_ENTRIES_IN_USE) ? PDATA_W'(cfg) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[PADDR_W-1:2] == REG_ENTRIES_IN_USE)) begin
      cfg <= pwdata[CFG_W-1:0];
    end
  end

  // A count above capacity acts as full capacity.
  assign n_eff    = (32'(cfg) > MAX_ENTRIES) ? NW'(MAX_ENTRIES) : NW'(cfg);
  assign last_idx = AW'(n_eff - NW'(1));

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign slot_ok  = (32'(in_data.entry_index) < MAX_ENTRIES);
  assign tbl_we   = in_acc && (in_data.mode == MODE_WRITE) && slot_ok;
  assign wr_entry = '{x: in_data.x_value, y: in_data.y_value};

  plti_table #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (AW'(in_data.entry_index)),
    .wdata (wr_entry),
    .raddr (raddr),
    .rdata (rd)
  );

  // Segment arithmetic on the registered bracket.
  assign span33   = {hi.x[DATA_W-1], hi.x} - {lo.x[DATA_W-1], lo.x};
  assign dx33     = {qx[DATA_W-1], qx} - {lo.x[DATA_W-1], lo.x};
  assign dy33     = {hi.y[DATA_W-1], hi.y} - {lo.y[DATA_W-1], lo.y};
  assign dy_neg33 = -dy33;
  assign mag      = dy33[DATA_W] ? dy_neg33[DATA_W-1:0] : dy33[DATA_W-1:0];
  assign span_pos = !span33[DATA_W] && (span33 != '0);

  plti_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mag),
    .b       (dx33[DATA_W-1:0]),
    .product (product),
    .stat    (mul_stat)
  );

  plti_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (span_r),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // The quotient never exceeds |dy|, so saturation only guards the format.
  assign sum34 = neg ? ({{2{lo.y[DATA_W-1]}}, lo.y} - {2'b00, quotient})
                     : ({{2{lo.y[DATA_W-1]}}, lo.y} + {2'b00, quotient});

  always_comb begin
    if (sum34[DATA_W+1] && (sum34[DATA_W:DATA_W-1] != 2'b11)) begin
      sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else if (!sum34[DATA_W+1] && (sum34[DATA_W:DATA_W-1] != 2'b00)) begin
      sat = {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sat = sum34[DATA_W-1:0];
    end
  end

  assign load_out = (state == S_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    raddr      = '0;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_acc && (in_data.mode == MODE_QUERY)) begin
          state_next = (n_eff == '0) ? S_DONE : S_CHK_FIRST;
        end
      end
      S_CHK_FIRST: begin
        if (qx <= rd.x) begin
          state_next = S_DONE;
        end else begin
          raddr      = last_idx;
          state_next = S_CHK_LAST;
        end
      end
      S_CHK_LAST: begin
        if (qx >= rd.x) begin
          state_next = S_DONE;
        end else begin
          raddr      = AW'(1);
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (qx <= rd.x) begin
          state_next = S_SPAN;
        end else begin
          raddr = idx + AW'(1);
        end
      end
      S_SPAN: begin
        if (span_pos) begin
          mul_start  = 1'b1;
          state_next = S_MUL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_MUL: begin
        if (mul_stat.done) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Query datapath: the scan keeps the last entry below x as the lower breakpoint.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        qx  <= in_data.x_value;
        res <= '0;
        st  <= ST_EMPTY;
      end
      S_CHK_FIRST: begin
        lo  <= rd;
        res <= rd.y;
        st  <= ST_OK;
      end
      S_CHK_LAST: begin
        res <= rd.y;
        idx <= AW'(1);
      end
      S_SCAN: begin
        if (qx <= rd.x) begin
          hi <= rd;
        end else begin
          lo  <= rd;
          idx <= idx + AW'(1);
        end
      end
      S_SPAN: begin
        span_r <= span33[DATA_W-1:0];
        neg    <= dy33[DATA_W];
        res    <= lo.y;
        st     <= span_pos ? ST_OK : ST_ZERO_SPAN;
      end
      S_DIV: begin
        if (div_stat.done) begin
          res <= sat;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.result_value <= res;
      out_data.status       <= st;
    end
  end

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (idx <= last_idx))
    else $error("segment scan ran past the last breakpoint");

  a_dx_in_span: assert property (@(posedge clk) disable iff (rst)
    (state == S_SPAN) && span_pos |-> !dx33[DATA_W] && (dx33 != '0) && (dx33 <= span33))
    else $error("query x lies outside the chosen segment");

  a_mul_done_state: assert property (@(posedge clk) disable iff (rst)
    mul_stat.done |-> (state == S_MUL))
    else $error("multiplier finished outside the multiply phase");

endmodule
